>>> sv/prs_pkg.sv
// Shared constants and types for the precharge relay supervisor.
package prs_pkg;

	localparam int SAMPLE_W = 16;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 3;

	// Relay state codes
	localparam logic [1:0] ST_OPEN   = 2'd0;
	localparam logic [1:0] ST_CLOSED = 2'd1;
	localparam logic [1:0] ST_FLOAT  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_RATIO  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_BATTERY  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TS_FLOOR     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOGGLE       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FAULT        = 3'd4;

	// Configuration reset values
	localparam logic [CFG_W-1:0] RST_CLOSE_RATIO = 16'd62259;
	localparam logic [CFG_W-1:0] RST_MIN_BATTERY = 16'd31500;
	localparam logic [CFG_W-1:0] RST_TS_FLOOR    = 16'd500;
	localparam logic [CFG_W-1:0] RST_TOGGLE      = 16'd4;
	localparam logic [CFG_W-1:0] RST_FAULT       = 16'd200;

	localparam logic [CFG_W-1:0] CNT_SAT = 16'hFFFF;

	// Request from the control logic into the sample window
	typedef struct packed {
		logic                start;
		logic [SAMPLE_W-1:0] ts;
		logic [SAMPLE_W-1:0] bt;
	} prs_win_req_t;

endpackage

>>> sv/prs_if.sv
// Valid/ready channel interfaces for sample requests and relay results.
interface prs_in_if import prs_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] ts_sample;
	logic [SAMPLE_W-1:0] battery_sample;

	modport source (output valid, output ts_sample, output battery_sample, input ready);
	modport sink (input valid, input ts_sample, input battery_sample, output ready);
endinterface

interface prs_out_if;
	logic       valid;
	logic       ready;
	logic       relay_on;
	logic [1:0] relay_state;
	logic       state_changed;

	modport source (output valid, output relay_on, output relay_state, output state_changed,
		input ready);
	modport sink (input valid, input relay_on, input relay_state, input state_changed,
		output ready);
endinterface

>>> sv/prs_window.sv
// Moving-average sample window: sample memory, running sums and fill count.
module prs_window import prs_pkg::*; #(
	parameter int WINDOW_LEN = 20
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  prs_win_req_t             req,
	output logic                     done,
	output logic [SAMPLE_W+$clog2(WINDOW_LEN+1)-1:0] ts_sum,
	output logic [SAMPLE_W+$clog2(WINDOW_LEN+1)-1:0] bt_sum,
	output logic [$clog2(WINDOW_LEN+1)-1:0]          fill
);

	localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
	localparam int SUM_W  = SAMPLE_W + CNT_W;
	localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(WINDOW_LEN);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);

	logic [2*SAMPLE_W-1:0] mem [WINDOW_LEN];
	logic [2*SAMPLE_W-1:0] rd_s1;
	logic [SAMPLE_W-1:0]   ts_s1;
	logic [SAMPLE_W-1:0]   bt_s1;
	logic                  busy_s1;
	logic                  done_q;
	logic [SUM_W-1:0]      ts_sum_q;
	logic [SUM_W-1:0]      bt_sum_q;
	logic [CNT_W-1:0]      fill_q;
	logic [SLOT_W-1:0]     slot_q;
	logic                  full;
	logic [SUM_W-1:0]      ts_old;
	logic [SUM_W-1:0]      bt_old;

	// Read the slot that the new sample replaces and capture the sample; then write the captured sample into that slot
	always_ff @(posedge clk) begin
		if (req.start) begin
			rd_s1 <= mem[slot_q];
			ts_s1 <= req.ts;
			bt_s1 <= req.bt;
		end
		if (busy_s1) begin
			mem[slot_q] <= {ts_s1, bt_s1};
		end
	end

	assign full   = (fill_q == FULL_CNT);
	assign ts_old = full ? SUM_W'(rd_s1[2*SAMPLE_W-1:SAMPLE_W]) : '0;
	assign bt_old = full ? SUM_W'(rd_s1[SAMPLE_W-1:0]) : '0;

	// Drop the oldest sample once full, add the new one, advance the slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1  <= 1'b0;
			done_q   <= 1'b0;
			ts_sum_q <= '0;
			bt_sum_q <= '0;
			fill_q   <= '0;
			slot_q   <= '0;
		end else begin
			busy_s1 <= req.start;
			done_q  <= busy_s1;
			if (busy_s1) begin
				ts_sum_q <= ts_sum_q - ts_old + SUM_W'(ts_s1);
				bt_sum_q <= bt_sum_q - bt_old + SUM_W'(bt_s1);
				if (!full) begin
					fill_q <= fill_q + 1'b1;
				end
				slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
			end
		end
	end

	assign done   = done_q;
	assign ts_sum = ts_sum_q;
	assign bt_sum = bt_sum_q;
	assign fill   = fill_q;

endmodule

>>> sv/precharge_relay_supervisor_top.sv
// Precharge relay supervisor: windowed averages, condition classifier, debounced relay control.
// A new request is accepted only in idle: the window memory access plus three
// passes through the single shared comparison multiplier and the decision must
// finish before the next request can be taken.
// A full result register stalls the final step until the result is taken.
// Reset clears sums, fill count, debounce counters, state (open) and relay drive.
module precharge_relay_supervisor_top import prs_pkg::*; #(
	parameter int WINDOW_LEN = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	prs_in_if.sink               in_ch,
	prs_out_if.source            out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
	localparam int SUM_W  = SAMPLE_W + CNT_W;
	localparam int PROD_W = SUM_W + CFG_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WIN  = 3'd1;
	localparam logic [2:0] S_P0   = 3'd2;
	localparam logic [2:0] S_P1   = 3'd3;
	localparam logic [2:0] S_P2   = 3'd4;
	localparam logic [2:0] S_P3   = 3'd5;

	logic [2:0]       state_q;
	logic [CFG_W-1:0] close_ratio_q;
	logic [CFG_W-1:0] min_battery_q;
	logic [CFG_W-1:0] ts_floor_q;
	logic [CFG_W-1:0] toggle_q;
	logic [CFG_W-1:0] fault_q;

	prs_win_req_t     win_req;
	logic             win_done;
	logic [SUM_W-1:0] ts_sum;
	logic [SUM_W-1:0] bt_sum;
	logic [CNT_W-1:0] fill;

	logic [SUM_W-1:0]  mul_a;
	logic [CFG_W-1:0]  mul_b;
	logic [PROD_W-1:0] prod_q;
	logic              lt_min_q;
	logic              ge_close_q;
	logic              gt_floor;
	logic [1:0]        cond;

	logic [CFG_W-1:0] close_cnt_q;
	logic [CFG_W-1:0] open_cnt_q;
	logic [CFG_W-1:0] float_cnt_q;
	logic [CFG_W-1:0] close_cnt_d;
	logic [CFG_W-1:0] open_cnt_d;
	logic [CFG_W-1:0] float_cnt_d;
	logic             fire_close;
	logic             fire_open;
	logic             fire_float;
	logic [1:0]       cur_state_q;
	logic             drive_q;
	logic [1:0]       next_state;
	logic             next_drive;

	logic             out_valid_q;
	logic             relay_on_q;
	logic [1:0]       relay_state_q;
	logic             changed_q;
	logic             out_free;
	logic             accept;

	assign in_ch.ready = (state_q == S_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;

	assign win_req.start = accept;
	assign win_req.ts    = in_ch.ts_sample;
	assign win_req.bt    = in_ch.battery_sample;

	prs_window #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (win_req),
		.done   (win_done),
		.ts_sum (ts_sum),
		.bt_sum (bt_sum),
		.fill   (fill)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			close_ratio_q <= RST_CLOSE_RATIO;
			min_battery_q <= RST_MIN_BATTERY;
			ts_floor_q    <= RST_TS_FLOOR;
			toggle_q      <= RST_TOGGLE;
			fault_q       <= RST_FAULT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CLOSE_RATIO: close_ratio_q <= cfg_data;
				REG_MIN_BATTERY: min_battery_q <= cfg_data;
				REG_TS_FLOOR:    ts_floor_q    <= cfg_data;
				REG_TOGGLE:      toggle_q      <= cfg_data;
				REG_FAULT:       fault_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Select operands of the shared multiplier
	always_comb begin
		case (state_q)
			S_P1: begin
				mul_a = bt_sum;
				mul_b = close_ratio_q;
			end
			S_P2: begin
				mul_a = SUM_W'(fill);
				mul_b = ts_floor_q;
			end
			default: begin
				mul_a = SUM_W'(fill);
				mul_b = min_battery_q;
			end
		endcase
	end

	// Hold each product and the comparison it feeds
	always_ff @(posedge clk) begin
		if (state_q == S_P0 || state_q == S_P1 || state_q == S_P2) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end
		if (state_q == S_P1) begin
			lt_min_q <= PROD_W'(bt_sum) < prod_q;
		end
		if (state_q == S_P2) begin
			ge_close_q <= {ts_sum, {CFG_W{1'b0}}} >= prod_q;
		end
	end

	assign gt_floor = PROD_W'(ts_sum) > prod_q;

	// Classify the period
	always_comb begin
		if (lt_min_q) begin
			cond = ST_OPEN;
		end else if (ge_close_q) begin
			cond = ST_CLOSED;
		end else if (gt_floor) begin
			cond = ST_FLOAT;
		end else begin
			cond = ST_OPEN;
		end
	end

	// Debounce counters: count while the condition holds, saturate, clear otherwise
	always_comb begin
		close_cnt_d = '0;
		open_cnt_d  = '0;
		float_cnt_d = '0;
		if (cond == ST_CLOSED) begin
			close_cnt_d = (close_cnt_q == CNT_SAT) ? close_cnt_q : close_cnt_q + 1'b1;
		end
		if (cond == ST_OPEN) begin
			open_cnt_d = (open_cnt_q == CNT_SAT) ? open_cnt_q : open_cnt_q + 1'b1;
		end
		if (cond == ST_FLOAT) begin
			float_cnt_d = (float_cnt_q == CNT_SAT) ? float_cnt_q : float_cnt_q + 1'b1;
		end
		fire_close = (cond == ST_CLOSED) && (close_cnt_d >= toggle_q);
		fire_open  = (cond == ST_OPEN) && (open_cnt_d >= toggle_q);
		fire_float = (cond == ST_FLOAT) && (float_cnt_d >= fault_q);

		next_state = cur_state_q;
		next_drive = drive_q;
		if (fire_close) begin
			next_state = ST_CLOSED;
			next_drive = 1'b1;
		end
		if (fire_open) begin
			next_state = ST_OPEN;
			next_drive = 1'b0;
		end
		if (fire_float) begin
			next_state = ST_FLOAT;
			next_drive = 1'b0;
		end
	end

	// Sequence one request through window, products and decision
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			close_cnt_q <= '0;
			open_cnt_q  <= '0;
			float_cnt_q <= '0;
			cur_state_q <= ST_OPEN;
			drive_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Raise valid on a new result, drop it once the result is taken
			if (state_q == S_P3 && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_WIN;
					end
				end
				S_WIN: begin
					if (win_done) begin
						state_q <= S_P0;
					end
				end
				S_P0: state_q <= S_P1;
				S_P1: state_q <= S_P2;
				S_P2: state_q <= S_P3;
				S_P3: begin
					if (out_free) begin
						close_cnt_q <= close_cnt_d;
						open_cnt_q  <= open_cnt_d;
						float_cnt_q <= float_cnt_d;
						cur_state_q <= next_state;
						drive_q     <= next_drive;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (state_q == S_P3 && out_free) begin
			relay_on_q    <= next_drive;
			relay_state_q <= next_state;
			changed_q     <= (next_state != cur_state_q);
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.relay_on      = relay_on_q;
	assign out_ch.relay_state   = relay_state_q;
	assign out_ch.state_changed = changed_q;

endmodule
